FILE: sv/tksl_pkg.sv
package tksl_pkg;

	localparam int LIST_DEPTH   = 16;
	localparam int CONCEPT_BITS = 16;
	localparam int TOTAL_W      = 32;
	localparam int LIMIT_W      = 5;
	localparam int CNT_W        = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	typedef struct packed {
		logic [CONCEPT_BITS-1:0] concept;
		logic [TOTAL_W-1:0]      total;
	} entry_t;

	typedef struct packed {
		logic we;
		logic slot_valid;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} emit_state_t;

endpackage

FILE: sv/tksl_cell.sv
module tksl_cell (
	input  logic               clk,
	input  tksl_pkg::cell_ctl_t ctl,
	input  tksl_pkg::entry_t    new_ent,
	input  tksl_pkg::entry_t    prev_ent,
	input  tksl_pkg::entry_t    next_ent,
	input  logic               prev_cand,
	input  logic               next_lt,
	input  logic               above,
	output tksl_pkg::entry_t    ent,
	output logic               cand,
	output logic               lt,
	output logic               below
);
	import tksl_pkg::*;

	entry_t ent_q;
	entry_t ent_d;
	logic   gt;
	logic   hit;

	assign gt    = $signed(new_ent.total) > $signed(ent_q.total);
	assign cand  = ctl.slot_valid ? gt : 1'b1;
	assign lt    = ctl.slot_valid & ($signed(new_ent.total) < $signed(ent_q.total));
	assign hit   = ctl.slot_valid & (ent_q.concept == new_ent.concept);
	assign below = above | hit;
	assign ent   = ent_q;

	always_comb begin
		if (above) begin
			if (next_lt) begin
				ent_d = next_ent;
			end else if (lt) begin
				ent_d = new_ent;
			end else begin
				ent_d = ent_q;
			end
		end else if (hit) begin
			if (prev_cand) begin
				ent_d = prev_ent;
			end else if (next_lt) begin
				ent_d = next_ent;
			end else begin
				ent_d = new_ent;
			end
		end else begin
			if (prev_cand) begin
				ent_d = prev_ent;
			end else if (cand) begin
				ent_d = new_ent;
			end else begin
				ent_d = ent_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			ent_q <= ent_d;
		end
	end

endmodule

FILE: sv/tksl_emit.sv
module tksl_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tksl_pkg::CNT_W-1:0]  count,
	input  tksl_pkg::entry_t            rd_ent,
	output logic [tksl_pkg::IDX_W-1:0]  rd_idx,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [3:0]                  rank,
	output logic [15:0]                 entry_concept,
	output logic [31:0]                 entry_total,
	output logic                        list_empty,
	output logic                        last
);
	import tksl_pkg::*;

	emit_state_t state_q;
	emit_state_t state_d;
	logic [IDX_W-1:0] idx_q;
	logic             load;
	logic             is_last;
	logic             is_empty;
	logic             valid_q;
	logic [3:0]       rank_q;
	logic [15:0]      concept_q;
	logic [31:0]      total_q;
	logic             empty_q;
	logic             last_q;

	assign is_empty = (count == '0);
	assign is_last  = is_empty | ((CNT_W'(idx_q) + CNT_W'(1)) == count);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load && is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		load     = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EMIT: load = ~valid_q | out_ready;
			default: begin
				in_ready = 1'b0;
				load     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (is_empty) begin
				rank_q    <= '0;
				concept_q <= '0;
				total_q   <= '0;
				empty_q   <= 1'b1;
			end else begin
				rank_q    <= 4'(idx_q);
				concept_q <= 16'(rd_ent.concept);
				total_q   <= rd_ent.total;
				empty_q   <= 1'b0;
			end
			last_q <= is_last;
		end
	end

	assign rd_idx        = idx_q;
	assign out_valid     = valid_q;
	assign rank          = rank_q;
	assign entry_concept = concept_q;
	assign entry_total   = total_q;
	assign list_empty    = empty_q;
	assign last          = last_q;

endmodule

FILE: sv/top_k_sorted_list_update.sv
// Keeps one list of (concept, total) pairs sorted by total, highest first.
// Input channel: in_valid and in_ready with concept_id, new_total (signed
// Q16.16) and batch_end. Output channel: out_valid and out_ready with rank,
// entry_concept, entry_total, list_empty and last. The list limit is written
// through cfg_we and cfg_wdata; the user must write it only while the block
// is idle, a rule that the block itself leaves to the user. An update is
// applied by the row of cells at the edge where the input transfer takes
// place. With batch_end set, the input transfer starts the emitter, which
// then loads the results into the output register, one result per cycle
// while the receiver does not stall; an empty list yields a single empty
// marker. The emission counter steps through the cells. in_ready stays low
// until the last result of an emission has been loaded.
// When the receiver stalls, the output register holds its result and the
// emission waits; a new item can be taken while the final result waits.
// Reset empties the list, sets the limit to the full depth and clears the
// output valid flag; the cell contents and output data are not cleared.
module top_k_sorted_list_update (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tksl_pkg::LIMIT_W-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [15:0]                   concept_id,
	input  logic signed [31:0]            new_total,
	input  logic                          batch_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    rank,
	output logic [15:0]                   entry_concept,
	output logic signed [31:0]            entry_total,
	output logic                          list_empty,
	output logic                          last
);
	import tksl_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   eff_lim;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   trimmed;
	entry_t             new_ent;
	entry_t             ent [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] cand;
	logic [LIST_DEPTH-1:0] lt;
	logic [LIST_DEPTH-1:0] below;
	logic [LIST_DEPTH-1:0] slot_valid;
	logic               hit_any;
	logic               found;
	logic               room;
	logic               accept;
	logic               we;
	logic [IDX_W-1:0]   rd_idx;
	logic [31:0]        total_out;

	assign accept          = in_valid & in_ready;
	assign new_ent.concept = CONCEPT_BITS'(concept_id);
	assign new_ent.total   = new_total;

	assign eff_lim = (int'(limit_q) > LIST_DEPTH) ? CNT_W'(LIST_DEPTH) : CNT_W'(limit_q);
	assign cnt_inc = (int'(count_q) < LIST_DEPTH) ? count_q + CNT_W'(1) : count_q;
	assign trimmed = (cnt_inc > eff_lim) ? eff_lim : cnt_inc;
	assign room    = count_q < eff_lim;
	assign hit_any = below[LIST_DEPTH-1];
	assign found   = |(cand & slot_valid);
	assign we      = accept & (hit_any | found | room);

	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    prev_ent;
		entry_t    next_ent;
		logic      prev_cand;
		logic      next_lt;
		logic      above;

		assign slot_valid[g]  = CNT_W'(g) < count_q;
		assign ctl.we         = we;
		assign ctl.slot_valid = slot_valid[g];

		if (g == 0) begin : g_head
			assign prev_ent  = new_ent;
			assign prev_cand = 1'b0;
			assign above     = 1'b0;
		end else begin : g_body
			assign prev_ent  = ent[g-1];
			assign prev_cand = cand[g-1];
			assign above     = below[g-1];
		end

		if (g == LIST_DEPTH - 1) begin : g_tail
			assign next_ent = new_ent;
			assign next_lt  = 1'b0;
		end else begin : g_inner
			assign next_ent = ent[g+1];
			assign next_lt  = lt[g+1];
		end

		tksl_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_ent   (new_ent),
			.prev_ent  (prev_ent),
			.next_ent  (next_ent),
			.prev_cand (prev_cand),
			.next_lt   (next_lt),
			.above     (above),
			.ent       (ent[g]),
			.cand      (cand[g]),
			.lt        (lt[g]),
			.below     (below[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(LIST_DEPTH);
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept && !hit_any) begin
				if (found) begin
					count_q <= trimmed;
				end else if (room) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	tksl_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (accept & batch_end),
		.count         (count_q),
		.rd_ent        (ent[rd_idx]),
		.rd_idx        (rd_idx),
		.in_ready      (in_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.rank          (rank),
		.entry_concept (entry_concept),
		.entry_total   (total_out),
		.list_empty    (list_empty),
		.last          (last)
	);

	assign entry_total = total_out;

endmodule

FILE: sv/tksl_checker.sv
module tksl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        batch_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  rank,
	input logic [15:0] entry_concept,
	input logic [31:0] entry_total,
	input logic        list_empty,
	input logic        last
);

	// A stalled result holds still.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(entry_total)
			&& $stable(entry_concept) && $stable(last))
		else $error("stalled result changed");

	// The empty marker comes alone, with zero fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && list_empty |-> last && rank == 4'd0 && entry_concept == 16'd0
			&& entry_total == 32'd0)
		else $error("malformed empty result");

	// An emission runs without gaps, rank stepping by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && rank == 4'($past(rank) + 4'd1))
		else $error("emission gap or rank skip");

	// No new item is taken while an emission is under way.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && batch_end |=> !in_ready)
		else $error("input taken after emission start");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken during emission");

endmodule

bind top_k_sorted_list_update tksl_checker u_tksl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.batch_end     (batch_end),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.rank          (rank),
	.entry_concept (entry_concept),
	.entry_total   (entry_total),
	.list_empty    (list_empty),
	.last          (last)
);
